// ----- hdl/alc_pkg.sv -----
package alc_pkg;

  // Operation codes carried in the op and kind fields
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_GEN   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_AGE = 2'd0;
  localparam logic [1:0] CFG_COLS    = 2'd1;
  localparam logic [1:0] CFG_ROWS    = 2'd2;

  localparam int AGE_W = 8;
  localparam int DIM_W = 7;
  localparam int SUM_W = 20;

  typedef struct packed {
    logic [1:0]       op;
    logic [5:0]       col;
    logic [5:0]       row;
    logic [AGE_W-1:0] age;
  } alc_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AGE_W-1:0] cell_age;
    logic [SUM_W-1:0] age_sum;
  } alc_out_t;

endpackage

// ----- hdl/aged_life_automaton_step_unit.sv -----
// Aged Life step unit. The grid of cell ages sits in a synchronous memory
// that is swept to zero after reset; busy stays high while that clearing
// pass writes all MAX_ROWS times 2**clog2(MAX_COLS) words.
// Configuration writes are taken in every cycle. For a cell write, a cell
// read or an unused op a new word may start in every cycle while busy is
// low, and its result strobes after the st1 stage and the result register.
// A generation holds busy while it walks the rows: each column of the 3x3
// window costs three reads of the single grid read port plus an evaluate
// step, then a copy pass writes the new ages back and clears the border;
// the result strobes from the drain state through the result register.
// Results cannot be held off: each one is valid for exactly one cycle.
module aged_life_automaton_step_unit import alc_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  alc_in_t          in_i,
  output logic             res_strobe_o,
  output alc_out_t         res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_idx_i,
  input  logic [AGE_W-1:0] cfg_data_i
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + RW;
  localparam int DEPTH = MAX_ROWS * (2 ** CW);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_GRD, ST_GSH, ST_CPY, ST_CDRN
  } state_e;

  state_e st_q;

  logic [AGE_W-1:0] max_age_q;
  logic [DIM_W-1:0] cols_q, rows_q, nc, nr;

  logic [AW-1:0]    clr_q;
  logic [DIM_W-1:0] r_q, x_q;
  logic [1:0]       k_q;
  logic [SUM_W-1:0] total_q;
  logic [AGE_W-1:0] c1_q [3];
  logic [AGE_W-1:0] c2_q [3];
  logic [AGE_W-1:0] nb_q [2];
  logic [AGE_W-1:0] w2 [3];

  logic             cpy_pend_q, cpy_edge_q;
  logic [AW-1:0]    cpy_addr_q;

  logic             st1_vld_q, st1_in_q;
  logic [1:0]       st1_op_q;
  logic             res_strobe_q;
  alc_out_t         res_q;

  logic             accept, in_rect;
  logic             g_we, n_we;
  logic [AW-1:0]    g_waddr, g_raddr, n_waddr, n_raddr;
  logic [AGE_W-1:0] g_wdata, g_rdata, n_rdata, nv;
  logic [AGE_W-1:0] nbr [8];

  function automatic logic [AW-1:0] cell_addr(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c);
    return {RW'(r), CW'(c)};
  endfunction

  // Saturate the in-use sizes
  always_comb begin
    if (cols_q < 7'd3) begin
      nc = 7'd3;
    end else if (int'(cols_q) > MAX_COLS) begin
      nc = DIM_W'(MAX_COLS);
    end else begin
      nc = cols_q;
    end
    if (rows_q < 7'd3) begin
      nr = 7'd3;
    end else if (int'(rows_q) > MAX_ROWS) begin
      nr = DIM_W'(MAX_ROWS);
    end else begin
      nr = rows_q;
    end
  end

  assign busy        = (st_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign in_rect     = ({1'b0, in_i.col} < nc) && ({1'b0, in_i.row} < nr);

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= 8'd64;
      cols_q    <= 7'd64;
      rows_q    <= 7'd64;
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        CFG_MAX_AGE: max_age_q <= cfg_data_i;
        CFG_COLS:    cols_q    <= cfg_data_i[DIM_W-1:0];
        CFG_ROWS:    rows_q    <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Window: left and center columns held, right column from the last reads
  assign w2[0] = nb_q[0];
  assign w2[1] = nb_q[1];
  assign w2[2] = g_rdata;

  assign nbr[0] = c1_q[0];
  assign nbr[1] = c1_q[1];
  assign nbr[2] = c1_q[2];
  assign nbr[3] = c2_q[0];
  assign nbr[4] = c2_q[2];
  assign nbr[5] = w2[0];
  assign nbr[6] = w2[1];
  assign nbr[7] = w2[2];

  alc_rule u_rule (
    .self_i    (c2_q[1]),
    .nbr_i     (nbr),
    .max_age_i (max_age_q),
    .next_o    (nv)
  );

  // Steer the grid ports
  always_comb begin
    g_we    = 1'b0;
    g_waddr = cell_addr({1'b0, in_i.row}, {1'b0, in_i.col});
    g_wdata = in_i.age;
    if (st_q == ST_CLEAR) begin
      g_we    = 1'b1;
      g_waddr = clr_q;
      g_wdata = '0;
    end else if (cpy_pend_q) begin
      g_we    = 1'b1;
      g_waddr = cpy_addr_q;
      g_wdata = cpy_edge_q ? '0 : n_rdata;
    end else if (accept && in_i.op == OP_WRITE && in_rect) begin
      g_we    = 1'b1;
    end
    if (st_q == ST_IDLE) begin
      g_raddr = cell_addr({1'b0, in_i.row}, {1'b0, in_i.col});
    end else begin
      g_raddr = cell_addr(r_q - 7'd1 + {5'd0, k_q}, x_q);
    end
  end

  assign n_we    = (st_q == ST_GSH) && (x_q >= 7'd2);
  assign n_waddr = cell_addr(r_q, x_q - 7'd1);
  assign n_raddr = cell_addr(r_q, x_q);

  alc_ram #(.AW(AW), .DEPTH(DEPTH)) u_grid (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  alc_ram #(.AW(AW), .DEPTH(DEPTH)) u_next (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (nv),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  // Sequence the clearing pass, the generation sweep and the copy pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_CLEAR;
      clr_q      <= '0;
      r_q        <= '0;
      x_q        <= '0;
      k_q        <= '0;
      cpy_pend_q <= 1'b0;
    end else begin
      cpy_pend_q <= 1'b0;
      case (st_q)
        ST_CLEAR: begin
          if (clr_q == AW'(DEPTH - 1)) begin
            st_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept && in_i.op == OP_GEN) begin
            st_q <= ST_GRD;
            r_q  <= 7'd1;
            x_q  <= '0;
            k_q  <= '0;
          end
        end
        ST_GRD: begin
          if (k_q == 2'd2) begin
            k_q  <= '0;
            st_q <= ST_GSH;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        ST_GSH: begin
          if (x_q == nc - 7'd1) begin
            x_q <= '0;
            if (r_q == nr - 7'd2) begin
              r_q  <= '0;
              st_q <= ST_CPY;
            end else begin
              r_q  <= r_q + 7'd1;
              st_q <= ST_GRD;
            end
          end else begin
            x_q  <= x_q + 7'd1;
            st_q <= ST_GRD;
          end
        end
        ST_CPY: begin
          cpy_pend_q <= 1'b1;
          if (x_q == nc - 7'd1) begin
            x_q <= '0;
            if (r_q == nr - 7'd1) begin
              st_q <= ST_CDRN;
            end else begin
              r_q <= r_q + 7'd1;
            end
          end else begin
            x_q <= x_q + 7'd1;
          end
        end
        ST_CDRN: begin
          st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // Capture window columns, running total and copy write address
  always_ff @(posedge clk_i) begin
    if (accept && in_i.op == OP_GEN) begin
      total_q <= '0;
    end
    if (st_q == ST_GRD && k_q == 2'd1) begin
      nb_q[0] <= g_rdata;
    end
    if (st_q == ST_GRD && k_q == 2'd2) begin
      nb_q[1] <= g_rdata;
    end
    if (st_q == ST_GSH) begin
      c1_q <= c2_q;
      c2_q <= w2;
      if (x_q >= 7'd2) begin
        total_q <= total_q + {{(SUM_W - AGE_W){1'b0}}, nv};
      end
    end
    if (st_q == ST_CPY) begin
      cpy_addr_q <= cell_addr(r_q, x_q);
      cpy_edge_q <= (r_q == '0) || (x_q == '0) || (r_q == nr - 7'd1) || (x_q == nc - 7'd1);
    end
  end

  // Advance the single-cell result stage and drive the strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_vld_q    <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      st1_vld_q    <= accept && in_i.op != OP_GEN;
      res_strobe_q <= st1_vld_q || (st_q == ST_CDRN);
    end
  end

  always_ff @(posedge clk_i) begin
    st1_op_q <= in_i.op;
    st1_in_q <= in_rect;
    if (st_q == ST_CDRN) begin
      res_q.kind     <= OP_GEN;
      res_q.cell_age <= '0;
      res_q.age_sum  <= total_q;
    end else begin
      res_q.kind     <= st1_op_q;
      res_q.cell_age <= (st1_op_q == OP_READ && st1_in_q) ? g_rdata : '0;
      res_q.age_sum  <= '0;
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

// ----- hdl/alc_ram.sv -----
module alc_ram import alc_pkg::*; #(
  parameter int AW    = 12,
  parameter int DEPTH = 4096
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [AGE_W-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [AGE_W-1:0] rdata_o
);

  logic [AGE_W-1:0] mem [DEPTH];
  logic [AGE_W-1:0] rdata_q;

  // Write one word, read one word with a registered result
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/alc_rule.sv -----
module alc_rule import alc_pkg::*; (
  input  logic [AGE_W-1:0] self_i,
  input  logic [AGE_W-1:0] nbr_i [8],
  input  logic [AGE_W-1:0] max_age_i,
  output logic [AGE_W-1:0] next_o
);

  logic [4:0] sum;

  function automatic logic [1:0] weight(logic [AGE_W-1:0] a, logic [AGE_W-1:0] m);
    logic [1:0] w;
    if (a == '0) begin
      w = 2'd0;
    end else if (a > m) begin
      w = 2'd3;
    end else begin
      w = 2'd1;
    end
    return w;
  endfunction

  // Add up the neighbor weights
  always_comb begin
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + {3'b000, weight(nbr_i[i], max_age_i)};
    end
  end

  // Age a survivor, give birth, or drop to dead
  always_comb begin
    if (self_i != '0) begin
      next_o = (sum == 5'd2 || sum == 5'd3) ? self_i + 8'd1 : '0;
    end else begin
      next_o = (sum == 5'd3) ? 8'd1 : '0;
    end
  end

endmodule

// ----- hdl/alc_chk.sv -----
module alc_chk import alc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input alc_in_t          in_i,
  input logic             res_strobe_o,
  input alc_out_t         res_o
);

  // A cell word is answered by a result strobe
  a_cell_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.op != OP_GEN) |-> ##2 res_strobe_o)
    else $error("cell word result missing");

  // The result kind echoes the op of that word
  a_kind_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.op != OP_GEN) |-> ##2 (res_o.kind == $past(in_i.op, 2)))
    else $error("result kind mismatch");

  // A generation keeps the block busy
  a_gen_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.op == OP_GEN) |=> busy)
    else $error("generation not busy");

  // Only reads carry a cell age
  a_age_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.kind != OP_READ) |-> (res_o.cell_age == '0))
    else $error("cell age on non-read result");

  // Only generations carry a sum
  a_sum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.kind != OP_GEN) |-> (res_o.age_sum == '0))
    else $error("age sum on non-generation result");

endmodule

bind aged_life_automaton_step_unit alc_chk u_alc_chk (.*);

// ----- sim/aged_life_automaton_step_unit_test.sv -----
`timescale 1ns / 100ps

module aged_life_automaton_step_unit_test;
  import alc_pkg::*;

  localparam int GRID_COLS  = 64;
  localparam int GRID_ROWS  = 64;
  localparam int CYCLE_CAP  = 3_000_000;
  localparam int PHASE_WORDS = 290;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  alc_in_t  in_i;
  logic     res_strobe_o;
  alc_out_t res_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic [1:0]       cfg_idx_i;
  logic [AGE_W-1:0] cfg_data_i;

  aged_life_automaton_step_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .in_i         (in_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Shadow copy of the grid and the registers
  logic [7:0] ages [0:GRID_ROWS*GRID_COLS-1];
  logic [7:0] ages_next [0:GRID_ROWS*GRID_COLS-1];
  logic [7:0] shadow_max_age;
  logic [6:0] shadow_cols;
  logic [6:0] shadow_rows;

  alc_out_t pending_results [$];
  int       mismatches = 0;
  int       cycles = 0;
  int       sender_idle_pct;

  // Directed words; chk marks rows whose result is typed in
  typedef struct {
    alc_in_t  w;
    bit       chk;
    alc_out_t res;
  } stim_row_t;

  stim_row_t directed [] = '{
    '{'{OP_READ,  6'd0,  6'd0,  8'd0},   1'b1, '{OP_READ,  8'd0,   20'd0}},
    '{'{OP_READ,  6'd63, 6'd63, 8'd0},   1'b1, '{OP_READ,  8'd0,   20'd0}},
    '{'{OP_WRITE, 6'd63, 6'd63, 8'd255}, 1'b1, '{OP_WRITE, 8'd0,   20'd0}},
    '{'{OP_READ,  6'd63, 6'd63, 8'd0},   1'b1, '{OP_READ,  8'd255, 20'd0}},
    '{'{OP_NONE,  6'd21, 6'd42, 8'hAA},  1'b1, '{OP_NONE,  8'd0,   20'd0}},
    '{'{OP_WRITE, 6'd10, 6'd10, 8'd1},   1'b0, '{OP_WRITE, 8'd0,   20'd0}},
    '{'{OP_WRITE, 6'd11, 6'd10, 8'd1},   1'b0, '{OP_WRITE, 8'd0,   20'd0}},
    '{'{OP_WRITE, 6'd12, 6'd10, 8'd1},   1'b0, '{OP_WRITE, 8'd0,   20'd0}},
    '{'{OP_WRITE, 6'd31, 6'd30, 8'd255}, 1'b0, '{OP_WRITE, 8'd0,   20'd0}},
    '{'{OP_WRITE, 6'd30, 6'd29, 8'd1},   1'b0, '{OP_WRITE, 8'd0,   20'd0}},
    '{'{OP_WRITE, 6'd30, 6'd31, 8'd1},   1'b0, '{OP_WRITE, 8'd0,   20'd0}},
    '{'{OP_WRITE, 6'd41, 6'd41, 8'd100}, 1'b0, '{OP_WRITE, 8'd0,   20'd0}},
    '{'{OP_WRITE, 6'd0,  6'd5,  8'd7},   1'b0, '{OP_WRITE, 8'd0,   20'd0}},
    '{'{OP_GEN,   6'd0,  6'd0,  8'd0},   1'b0, '{OP_GEN,   8'd0,   20'd0}},
    '{'{OP_READ,  6'd31, 6'd30, 8'd0},   1'b0, '{OP_READ,  8'd0,   20'd0}},
    '{'{OP_READ,  6'd40, 6'd40, 8'd0},   1'b0, '{OP_READ,  8'd0,   20'd0}},
    '{'{OP_READ,  6'd11, 6'd9,  8'd0},   1'b0, '{OP_READ,  8'd0,   20'd0}},
    '{'{OP_READ,  6'd63, 6'd63, 8'd0},   1'b1, '{OP_READ,  8'd0,   20'd0}},
    '{'{OP_READ,  6'd0,  6'd5,  8'd0},   1'b1, '{OP_READ,  8'd0,   20'd0}},
    '{'{OP_GEN,   6'd0,  6'd0,  8'd0},   1'b0, '{OP_GEN,   8'd0,   20'd0}}
  };

  // Random phases: max_age, cols, rows as written (sizes saturate when used)
  logic [7:0] phase_cfg [6][3] = '{
    '{8'd0,   8'd0,   8'd2},
    '{8'd255, 8'd127, 8'd5},
    '{8'd1,   8'd8,   8'd8},
    '{8'd64,  8'd12,  8'd6},
    '{8'd3,   8'd200, 8'd64},
    '{8'd128, 8'd6,   8'd10}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int used_cols();
    if (shadow_cols < 3) return 3;
    if (shadow_cols > GRID_COLS) return GRID_COLS;
    return int'(shadow_cols);
  endfunction

  function automatic int used_rows();
    if (shadow_rows < 3) return 3;
    if (shadow_rows > GRID_ROWS) return GRID_ROWS;
    return int'(shadow_rows);
  endfunction

  function automatic int neighbor_weight(logic [7:0] a);
    if (a == 0) return 0;
    if (a > shadow_max_age) return 3;
    return 1;
  endfunction

  // Advance the shadow grid one generation and return the wrapped age sum
  function automatic logic [SUM_W-1:0] step_generation();
    int nc, nr, sum, k;
    logic [SUM_W-1:0] total;
    logic [7:0] self_age, nv;
    nc = used_cols();
    nr = used_rows();
    total = '0;
    for (int r = 1; r + 1 < nr; r++) begin
      for (int c = 1; c + 1 < nc; c++) begin
        sum = 0;
        self_age = ages[r*GRID_COLS + c];
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0)
              sum += neighbor_weight(ages[(r+dr)*GRID_COLS + c + dc]);
        if (self_age != 0)
          nv = (sum == 2 || sum == 3) ? self_age + 8'd1 : 8'd0;
        else
          nv = (sum == 3) ? 8'd1 : 8'd0;
        ages_next[r*GRID_COLS + c] = nv;
        total += SUM_W'(nv);
      end
    end
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        k = r*GRID_COLS + c;
        ages[k] = (r == 0 || c == 0 || r + 1 == nr || c + 1 == nc) ? 8'd0 : ages_next[k];
      end
    end
    return total;
  endfunction

  // Apply one accepted word to the shadow state and return its result
  function automatic alc_out_t predict_word(alc_in_t w);
    alc_out_t res;
    bit in_area;
    in_area = (w.col < used_cols()) && (w.row < used_rows());
    res = '{kind: w.op, cell_age: '0, age_sum: '0};
    case (w.op)
      OP_WRITE: if (in_area) ages[w.row*GRID_COLS + w.col] = w.age;
      OP_READ:  if (in_area) res.cell_age = ages[w.row*GRID_COLS + w.col];
      OP_GEN:   res.age_sum = step_generation();
      default: ;
    endcase
    return res;
  endfunction

  task automatic note_mismatch(string what, alc_out_t want, alc_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected kind %0d age %0d sum %0d, got kind %0d age %0d sum %0d",
               what, want.kind, want.cell_age, want.age_sum,
               got.kind, got.cell_age, got.age_sum);
  endtask

  // Hand one word to the block, idling beforehand at the current rate
  task automatic send_word(alc_in_t w, bit chk, alc_out_t typed);
    alc_out_t res;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    start <= 1'b1;
    in_i  <= w;
    do @(posedge clk_i); while (busy);
    res = predict_word(w);
    pending_results.push_back(chk ? typed : res);
  endtask

  // Leave valid high; the caller drops it after the last word
  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAX_AGE: shadow_max_age = data;
      CFG_COLS:    shadow_cols    = data[6:0];
      CFG_ROWS:    shadow_rows    = data[6:0];
      default: ;
    endcase
  endtask

  // Hold until every expected word has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic alc_in_t random_word();
    alc_in_t w;
    int pick, gen_pct;
    w.op  = OP_NONE;
    w.col = 6'($urandom_range(63));
    w.row = 6'($urandom_range(63));
    w.age = 8'($urandom_range(255));
    gen_pct = (used_cols() * used_rows() > 1000) ? 1 : 10;
    pick = $urandom_range(99);
    if (pick < gen_pct) w.op = OP_GEN;
    else if (pick < gen_pct + 50) w.op = OP_WRITE;
    else if (pick < 95) w.op = OP_READ;
    // Keep most addresses inside the in-use rectangle
    if ($urandom_range(3) != 0) begin
      w.col = 6'($urandom_range(used_cols() - 1));
      w.row = 6'($urandom_range(used_rows() - 1));
    end
    case ($urandom_range(5))
      0, 1: w.age = 8'($urandom_range(1, 3));
      2:    w.age = shadow_max_age + 8'($urandom_range(0, 1));
      3:    w.age = 8'd255;
      4:    w.age = 8'd0;
      default: ;
    endcase
    return w;
  endfunction

  // Check each strobed word against the oldest expectation
  always @(posedge clk_i) begin
    alc_out_t want;
    if (rst_ni && res_strobe_o) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected word", '0, res_o);
      end else begin
        want = pending_results.pop_front();
        if (res_o.kind != want.kind) note_mismatch("kind", want, res_o);
        else if (res_o.cell_age != want.cell_age) note_mismatch("cell_age", want, res_o);
        else if (res_o.age_sum != want.age_sum) note_mismatch("age_sum", want, res_o);
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    alc_out_t none;
    none = '0;
    sender_idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_idx_i = CFG_MAX_AGE;
    cfg_data_i = '0;
    for (int k = 0; k < GRID_ROWS*GRID_COLS; k++) begin
      ages[k] = '0;
      ages_next[k] = '0;
    end
    shadow_max_age = 8'd64;
    shadow_cols = 7'd64;
    shadow_rows = 7'd64;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (busy);

    // Walk the directed table at reset settings
    foreach (directed[i]) send_word(directed[i].w, directed[i].chk, directed[i].res);
    drain_results();

    // Random phases, idle rate stepping 32 -> 50 -> 0
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_MAX_AGE, phase_cfg[p][0]);
      write_reg(CFG_COLS,    phase_cfg[p][1]);
      write_reg(CFG_ROWS,    phase_cfg[p][2]);
      cfg_valid_i <= 1'b0;
      sender_idle_pct = (p < 2) ? 32 : (p < 4) ? 50 : 0;
      for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word(), 1'b0, none);
      drain_results();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
